@@ src/scp_pkg.sv @@
package scp_pkg;

  localparam int NUM_POINTS = 256;
  localparam int SLOTS_PER_POINT = 4;
  localparam int PT_W = 8;
  localparam int SLOT_W = (SLOTS_PER_POINT > 1) ? $clog2(SLOTS_PER_POINT) : 1;
  localparam int ROW_W = SLOTS_PER_POINT * 32;

  typedef enum logic [2:0] {
    CMD_INC    = 3'd0,
    CMD_REG    = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_READ   = 3'd3,
    CMD_FENCE  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  point_id;
    logic [31:0] threshold;
  } scp_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  out_point;
    logic [31:0] out_value;
    logic        ok;
    logic        last;
  } scp_out_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [2:0]  cmd;
    logic        in_range;
    logic [7:0]  point;
    logic [31:0] thr;
  } scp_cmd_t;

endpackage

@@ src/scp_front.sv @@
module scp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  scp_pkg::scp_in_t    in_data,
  output logic                q_valid,
  output scp_pkg::scp_cmd_t   q_data,
  input  logic                q_take
);
  import scp_pkg::*;

  // Two-entry queue between command intake and execution.
  scp_cmd_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  scp_cmd_t   cls;
  logic       push_ok, pop_ok;

  always_comb begin
    cls.cmd      = in_data.cmd;
    cls.point    = in_data.point_id;
    cls.thr      = in_data.threshold;
    cls.in_range = ({1'b0, in_data.point_id} < 9'(NUM_POINTS));
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign q_valid = (cnt_r != 2'd0);
  assign pop_ok  = q_take && q_valid;
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= !wr_ptr_r;
      if (pop_ok) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end
endmodule

@@ src/scp_back.sv @@
module scp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                async_mode,
  input  logic                q_valid,
  input  scp_pkg::scp_cmd_t   q_data,
  output logic                q_take,
  output logic                out_empty,
  input  logic                out_pop,
  output scp_pkg::scp_out_t   out_data
);
  import scp_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_RUN, S_REPLY} state_t;

  state_t   state_r;
  scp_cmd_t cur_r;

  // Counter, threshold and valid rows live in memories. A point whose flag
  // in seen_r is clear has never been written and reads as zero and empty.
  logic [31:0]                cnt_mem [NUM_POINTS];
  logic [ROW_W-1:0]           thr_mem [NUM_POINTS];
  logic [SLOTS_PER_POINT-1:0] vld_mem [NUM_POINTS];
  logic [NUM_POINTS-1:0]      seen_r;
  logic [31:0]                cnt_rd_r;
  logic [ROW_W-1:0]           thr_rd_r;
  logic [SLOTS_PER_POINT-1:0] vld_rd_r;
  logic                       seen_rd_r;
  logic [31:0]                cnt_base;

  // Working copy of one point.
  logic [31:0]                 val_r;
  logic [31:0]                 thr_w_r [SLOTS_PER_POINT];
  logic [SLOTS_PER_POINT-1:0]  vld_w_r;
  logic                        ok_r;

  logic     out_valid_r;
  scp_out_t out_r;

  // Combinational view of slot matches.
  logic [SLOTS_PER_POINT-1:0] reach, eqm;
  logic                       any_reach, any_eq, full;
  logic [SLOT_W-1:0]          first_reach, first_eq, first_free;
  logic                       out_free;
  logic                       load_irq, load_reply;

  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;
  assign q_take    = (state_r == S_IDLE) && q_valid;
  assign cnt_base  = seen_rd_r ? cnt_rd_r : 32'd0;

  assign load_irq   = (state_r == S_RUN) && (cur_r.cmd == CMD_INC) && any_reach &&
                      async_mode && out_free;
  assign load_reply = (state_r == S_REPLY) && out_free;

  always_comb begin
    any_reach   = 1'b0;
    any_eq      = 1'b0;
    first_reach = '0;
    first_eq    = '0;
    first_free  = '0;
    full        = 1'b1;
    for (int i = SLOTS_PER_POINT - 1; i >= 0; i--) begin
      reach[i] = vld_w_r[i] && (val_r >= thr_w_r[i]);
      eqm[i]   = vld_w_r[i] && (thr_w_r[i] == cur_r.thr);
      if (reach[i]) begin
        any_reach   = 1'b1;
        first_reach = SLOT_W'(i);
      end
      if (eqm[i]) begin
        any_eq   = 1'b1;
        first_eq = SLOT_W'(i);
      end
      if (!vld_w_r[i]) begin
        full       = 1'b0;
        first_free = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) begin
      cnt_rd_r  <= cnt_mem[q_data.point];
      thr_rd_r  <= thr_mem[q_data.point];
      vld_rd_r  <= vld_mem[q_data.point];
      seen_rd_r <= seen_r[q_data.point];
      cur_r     <= q_data;
    end
    if (rst_n && state_r == S_REPLY && out_free && cur_r.in_range) begin
      cnt_mem[cur_r.point] <= val_r;
      vld_mem[cur_r.point] <= vld_w_r;
      for (int i = 0; i < SLOTS_PER_POINT; i++) begin
        thr_mem[cur_r.point][i*32 +: 32] <= thr_w_r[i];
      end
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= '0;
    end else begin
      if (load_irq || load_reply) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) state_r <= S_READ;
        end
        S_READ: begin
          vld_w_r <= seen_rd_r ? vld_rd_r : '0;
          for (int i = 0; i < SLOTS_PER_POINT; i++) thr_w_r[i] <= thr_rd_r[i*32 +: 32];
          if (!cur_r.in_range) begin
            val_r   <= '0;
            ok_r    <= 1'b0;
            state_r <= S_REPLY;
          end else if (cur_r.cmd == CMD_INC) begin
            val_r   <= cnt_base + 32'd1;
            ok_r    <= 1'b1;
            state_r <= S_RUN;
          end else begin
            val_r   <= cnt_base;
            ok_r    <= 1'b0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          priority case (cur_r.cmd)
            CMD_INC: begin
              if (any_reach) begin
                if (!async_mode || out_free) begin
                  if (async_mode) begin
                    out_r.kind      <= 1'b1;
                    out_r.out_point <= cur_r.point;
                    out_r.out_value <= thr_w_r[first_reach];
                    out_r.ok        <= 1'b1;
                    out_r.last      <= 1'b0;
                  end
                  for (int i = 0; i < SLOTS_PER_POINT; i++) begin
                    if (i >= int'(first_reach)) begin
                      if (i + 1 < SLOTS_PER_POINT) begin
                        thr_w_r[i] <= thr_w_r[i+1];
                        vld_w_r[i] <= vld_w_r[i+1];
                      end else begin
                        vld_w_r[i] <= 1'b0;
                      end
                    end
                  end
                end
              end else begin
                state_r <= S_REPLY;
              end
            end
            CMD_REG: begin
              ok_r <= any_eq || !full;
              if (!any_eq && !full) begin
                thr_w_r[first_free] <= cur_r.thr;
                vld_w_r[first_free] <= 1'b1;
              end
              state_r <= S_REPLY;
            end
            CMD_CANCEL: begin
              ok_r <= any_eq;
              if (any_eq) begin
                for (int i = 0; i < SLOTS_PER_POINT; i++) begin
                  if (i >= int'(first_eq)) begin
                    if (i + 1 < SLOTS_PER_POINT) begin
                      thr_w_r[i] <= thr_w_r[i+1];
                      vld_w_r[i] <= vld_w_r[i+1];
                    end else begin
                      vld_w_r[i] <= 1'b0;
                    end
                  end
                end
              end
              state_r <= S_REPLY;
            end
            CMD_READ: begin
              ok_r    <= 1'b1;
              state_r <= S_REPLY;
            end
            CMD_FENCE: begin
              ok_r    <= !async_mode || (val_r >= cur_r.thr);
              state_r <= S_REPLY;
            end
            default: begin
              ok_r    <= 1'b0;
              state_r <= S_REPLY;
            end
          endcase
        end
        S_REPLY: begin
          if (out_free) begin
            out_r.kind      <= 1'b0;
            out_r.out_point <= cur_r.point;
            out_r.out_value <= val_r;
            out_r.ok        <= ok_r;
            out_r.last      <= 1'b1;
            if (cur_r.in_range) seen_r[cur_r.point] <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ src/syncpoint_counters_with_threshold_irq_unit.sv @@
// Syncpoint counter bank with threshold interrupts.
// Input channel: in_push/in_full carries one command item (cmd, point_id,
// threshold); an item is taken when in_push is high and in_full low.
// Result channel: out_empty/out_pop; while out_empty is low the oldest
// result sits on out_data and leaves on a cycle with out_pop high.
// Each command yields zero or more interrupt items (kind 1) in registration
// order, then one reply item with last set.
// Configuration: cfg_we writes cfg_async_mode; the user must do so only
// while the block idles, which the block itself does not enforce. A
// two-entry command queue decouples intake from execution. Execution
// steps through take with registered memory read, load, evaluate and
// reply with write-back; an out-of-range point skips evaluate, and an
// increment stays in evaluate while it removes reached thresholds. The
// first interrupt is loaded in evaluate, a reply in the reply state.
// When the receiver stalls, the output register holds and the execution
// unit waits; the queue then fills and in_full rises.
// Reset clears all counters to zero, empties all threshold lists and sets
// async mode; there is no clearing pass, a per-point written flag makes
// untouched counters and lists read as zero and empty.
module syncpoint_counters_with_threshold_irq_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  scp_pkg::scp_in_t   in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output scp_pkg::scp_out_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_async_mode
);
  import scp_pkg::*;

  logic     async_r;
  logic     q_valid, q_take;
  scp_cmd_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      async_r <= 1'b1;
    end else if (cfg_we) begin
      async_r <= cfg_async_mode;
    end
  end

  scp_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .q_valid, .q_data, .q_take
  );

  scp_back u_back (
    .clk, .rst_n, .async_mode(async_r), .q_valid, .q_data, .q_take,
    .out_empty, .out_pop, .out_data
  );

`ifndef SYNTH
  a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("take from empty queue");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result dropped under stall");
  a_irq_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.kind) |-> !out_data.last)
    else $error("interrupt marked last");
`endif
endmodule
